// ===== rtl/core/npdr_pkg.sv =====
`timescale 1ns / 1ps
// Shared widths, status codes, register indexes and luma constants for the
// pixel depth reducer. No dependencies.
package npdr_pkg;

	localparam int SAMPLE_W   = 8;
	localparam int STATUS_W   = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;
	localparam int DIM_W      = 13;

	localparam int DEF_MAX_WIDTH  = 4096;
	localparam int DEF_MAX_HEIGHT = 4096;

	typedef logic [STATUS_W-1:0] status_t;

	localparam status_t ST_DATA  = 3'd0;
	localparam status_t ST_DONE  = 3'd1;
	localparam status_t ST_OVER  = 3'd2;
	localparam status_t ST_TRUNC = 3'd3;
	localparam status_t ST_EXTRA = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAXVAL = 2'd3;

	localparam logic MODE_BILEVEL = 1'b0;
	localparam logic MODE_LUMA    = 1'b1;

	// 299r + 587g + 114b peaks at 255000
	localparam int LUMA_W = 18;
	localparam logic [LUMA_W-1:0] COEF_R = 18'd299;
	localparam logic [LUMA_W-1:0] COEF_G = 18'd587;
	localparam logic [LUMA_W-1:0] COEF_B = 18'd114;

	// x / 1000 == (x * ceil(2^28 / 1000)) >> 28, exact for x < 2^18
	localparam int RECIP_W     = 19;
	localparam int RECIP_SHIFT = 28;
	localparam logic [RECIP_W-1:0] RECIP_1000 = 19'd268436;

	localparam logic [1:0] COMP_RED   = 2'd0;
	localparam logic [1:0] COMP_GREEN = 2'd1;
	localparam logic [1:0] COMP_BLUE  = 2'd2;

endpackage

// ===== rtl/core/npdr_if.sv =====
`timescale 1ns / 1ps
// Channel interfaces for the pixel depth reducer: sample input, result output
// and register write. Depends on npdr_pkg.
interface npdr_in_if;
	logic                          valid;
	logic                          ready;
	logic [npdr_pkg::SAMPLE_W-1:0] sample;
	logic                          end_of_data;

	modport source (output valid, output sample, output end_of_data, input ready);
	modport sink (input valid, input sample, input end_of_data, output ready);
endinterface

interface npdr_out_if;
	logic                          valid;
	logic                          ready;
	logic [npdr_pkg::SAMPLE_W-1:0] out_byte;
	npdr_pkg::status_t             status;

	modport source (output valid, output out_byte, output status, input ready);
	modport sink (input valid, input out_byte, input status, output ready);
endinterface

interface npdr_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [npdr_pkg::CFG_IDX_W-1:0]  index;
	logic [npdr_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/netpbm_pixel_depth_reducer_core.sv =====
`timescale 1ns / 1ps
// Pixel depth reducer top level: register file, frame tracking and the
// result pipeline. Depends on npdr_pkg, npdr_if and npdr_div1000.
//
// Usage:
//   pix_in  takes one sample byte per word, or an end marker (end_of_data).
//   pix_out gives one word per packed bilevel byte, grey byte or status.
//   cfg     writes mode, image_width, image_height, max_value by index;
//           write only while no words are in flight. cfg.ready is always high.
// Mode 0 packs thresholded grey samples MSB first, rows padded with ones.
// Mode 1 turns r, g, b triples into one grey byte.
// A result passes the input register, the decision register and then the
// output register before it shows on pix_out. Throughput is one word per
// cycle while pix_out does not stall; the frame counters and the luma partial
// sum close their loop within the decision stage each cycle.
// Samples that only add to a packed byte or a triple give no result.
// Reset clears all frame state and returns the registers to their defaults.
// When pix_out stalls, the three stages fill up and pix_in.ready drops
// only once every stage holds a word; bubbles are squeezed out first.
module netpbm_pixel_depth_reducer_core #(
	parameter int MAX_WIDTH  = npdr_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = npdr_pkg::DEF_MAX_HEIGHT
) (
	input  logic        clk,
	input  logic        arst_n,
	npdr_in_if.sink     pix_in,
	npdr_out_if.source  pix_out,
	npdr_cfg_if.sink    cfg
);
	import npdr_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int XW = (WW > DIM_W) ? WW : DIM_W;
	localparam int YW = (HW > DIM_W) ? HW : DIM_W;

	// configuration
	logic                mode_q;
	logic [DIM_W-1:0]    width_q;
	logic [DIM_W-1:0]    height_q;
	logic [SAMPLE_W-1:0] maxval_q;

	// frame state
	logic [CW-1:0]       col_q;
	logic [RW-1:0]       row_q;
	logic [7:0]          bits_q;
	logic [2:0]          pos_q;
	logic [1:0]          comp_q;
	logic [LUMA_W-1:0]   luma_q;
	logic                err_q;
	logic                done_q;

	// pipeline
	logic                valid_s1;
	logic [SAMPLE_W-1:0] sample_s1;
	logic                eod_s1;
	logic                valid_s2;
	status_t             status_s2;
	logic [SAMPLE_W-1:0] byte_s2;
	logic                is_luma_s2;
	logic [LUMA_W-1:0]   sum_s2;
	logic                out_valid_q;
	logic [SAMPLE_W-1:0] out_byte_q;
	status_t             status_q;

	logic out_en, s2_en, s1_en, step;

	assign out_en = !out_valid_q || pix_out.ready;
	assign s2_en  = !valid_s2 || out_en;
	assign s1_en  = !valid_s1 || s2_en;
	assign step   = valid_s1 && s2_en;

	assign pix_in.ready    = s1_en;
	assign cfg.ready       = 1'b1;
	assign pix_out.valid   = out_valid_q;
	assign pix_out.out_byte = out_byte_q;
	assign pix_out.status  = status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_BILEVEL;
			width_q  <= DIM_W'(1);
			height_q <= DIM_W'(1);
			maxval_q <= 8'd255;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_MODE:   mode_q   <= cfg.data[0];
				REG_WIDTH:  width_q  <= cfg.data[DIM_W-1:0];
				REG_HEIGHT: height_q <= cfg.data[DIM_W-1:0];
				REG_MAXVAL: maxval_q <= cfg.data[SAMPLE_W-1:0];
				default: ;
			endcase
		end
	end

	// effective dimensions: zero reads as one, large values clip to the limit
	logic [WW-1:0] eff_w;
	logic [HW-1:0] eff_h;

	always_comb begin
		if (width_q == '0)
			eff_w = WW'(1);
		else if (XW'(width_q) > XW'(MAX_WIDTH))
			eff_w = WW'(MAX_WIDTH);
		else
			eff_w = WW'(width_q);
		if (height_q == '0)
			eff_h = HW'(1);
		else if (YW'(height_q) > YW'(MAX_HEIGHT))
			eff_h = HW'(MAX_HEIGHT);
		else
			eff_h = HW'(height_q);
	end

	logic row_end, row_last, black, over, trunc_ok;
	logic [7:0] bit_mask, bits_or;

	assign row_end  = (WW'(col_q) + WW'(1)) >= eff_w;
	assign row_last = (HW'(row_q) + HW'(1)) >= eff_h;
	assign black    = !(SAMPLE_W'(sample_s1) > SAMPLE_W'(({1'b0, maxval_q} + 9'd1) >> 1));
	assign over     = sample_s1 > maxval_q;
	assign trunc_ok = done_q && (mode_q == MODE_BILEVEL || comp_q == COMP_RED);
	assign bit_mask = 8'h80 >> pos_q;
	assign bits_or  = black ? (bits_q | bit_mask) : bits_q;

	// decision stage
	logic [CW-1:0]       col_d;
	logic [RW-1:0]       row_d;
	logic [7:0]          bits_d;
	logic [2:0]          pos_d;
	logic [1:0]          comp_d;
	logic [LUMA_W-1:0]   luma_d;
	logic                err_d, done_d;
	logic                emit;
	status_t             emit_status;
	logic [SAMPLE_W-1:0] emit_byte;
	logic                emit_luma;
	logic [LUMA_W-1:0]   emit_sum;
	logic                advance;

	always_comb begin
		col_d       = col_q;
		row_d       = row_q;
		bits_d      = bits_q;
		pos_d       = pos_q;
		comp_d      = comp_q;
		luma_d      = luma_q;
		err_d       = err_q;
		done_d      = done_q;
		emit        = 1'b0;
		emit_status = ST_DATA;
		emit_byte   = '0;
		emit_luma   = 1'b0;
		emit_sum    = luma_q + LUMA_W'(sample_s1) * COEF_B;
		advance     = 1'b0;
		if (eod_s1) begin
			if (!err_q) begin
				emit        = 1'b1;
				emit_status = trunc_ok ? ST_DONE : ST_TRUNC;
			end
			col_d  = '0;
			row_d  = '0;
			bits_d = '0;
			pos_d  = '0;
			comp_d = COMP_RED;
			luma_d = '0;
			err_d  = 1'b0;
			done_d = 1'b0;
		end else if (err_q) begin
			// swallow samples until the end marker
		end else if (done_q) begin
			err_d       = 1'b1;
			emit        = 1'b1;
			emit_status = ST_EXTRA;
		end else if (over) begin
			err_d       = 1'b1;
			emit        = 1'b1;
			emit_status = ST_OVER;
		end else if (mode_q == MODE_BILEVEL) begin
			advance = 1'b1;
			if (pos_q == 3'd7 || row_end) begin
				emit      = 1'b1;
				emit_byte = bits_or | (8'h7F >> pos_q);
				bits_d    = '0;
				pos_d     = '0;
			end else begin
				bits_d = bits_or;
				pos_d  = pos_q + 3'd1;
			end
		end else if (comp_q == COMP_RED) begin
			luma_d = LUMA_W'(sample_s1) * COEF_R;
			comp_d = COMP_GREEN;
		end else if (comp_q == COMP_GREEN) begin
			luma_d = luma_q + LUMA_W'(sample_s1) * COEF_G;
			comp_d = COMP_BLUE;
		end else begin
			emit      = 1'b1;
			emit_luma = 1'b1;
			comp_d    = COMP_RED;
			advance   = 1'b1;
		end
		if (advance) begin
			if (row_end) begin
				col_d = '0;
				if (row_last) begin
					row_d  = '0;
					done_d = 1'b1;
				end else begin
					row_d = RW'(row_q + RW'(1));
				end
			end else begin
				col_d = CW'(col_q + CW'(1));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			bits_q <= '0;
			pos_q  <= '0;
			comp_q <= COMP_RED;
			luma_q <= '0;
			err_q  <= 1'b0;
			done_q <= 1'b0;
		end else if (step) begin
			col_q  <= col_d;
			row_q  <= row_d;
			bits_q <= bits_d;
			pos_q  <= pos_d;
			comp_q <= comp_d;
			luma_q <= luma_d;
			err_q  <= err_d;
			done_q <= done_d;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s1_en)
			valid_s1 <= pix_in.valid;
	end

	always_ff @(posedge clk) begin
		if (s1_en && pix_in.valid) begin
			sample_s1 <= pix_in.sample;
			eod_s1    <= pix_in.end_of_data;
		end
	end

	// decision register; only words that give a result move on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (s2_en)
			valid_s2 <= step && emit;
	end

	always_ff @(posedge clk) begin
		if (step && emit) begin
			status_s2  <= emit_status;
			byte_s2    <= emit_byte;
			is_luma_s2 <= emit_luma;
			sum_s2     <= emit_sum;
		end
	end

	logic [SAMPLE_W-1:0] grey;

	npdr_div1000 u_div (
		.dividend (sum_s2),
		.quotient (grey)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_en)
			out_valid_q <= valid_s2;
	end

	always_ff @(posedge clk) begin
		if (out_en && valid_s2) begin
			out_byte_q <= is_luma_s2 ? grey : byte_s2;
			status_q   <= status_s2;
		end
	end

endmodule

// ===== rtl/core/npdr_div1000.sv =====
`timescale 1ns / 1ps
// Divide the weighted luma sum by 1000 with a reciprocal multiply.
// Depends on npdr_pkg.
module npdr_div1000 (
	input  logic [npdr_pkg::LUMA_W-1:0]   dividend,
	output logic [npdr_pkg::SAMPLE_W-1:0] quotient
);
	import npdr_pkg::*;

	logic [LUMA_W+RECIP_W-1:0] prod;

	assign prod     = (LUMA_W+RECIP_W)'(dividend) * (LUMA_W+RECIP_W)'(RECIP_1000);
	assign quotient = prod[RECIP_SHIFT +: SAMPLE_W];

endmodule

// ===== rtl/core/npdr_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the pixel depth reducer, bound to the top level.
// Depends on npdr_pkg and netpbm_pixel_depth_reducer_core.
module npdr_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [npdr_pkg::SAMPLE_W-1:0] out_byte,
	input npdr_pkg::status_t             status
);
	import npdr_pkg::*;

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(status))
		else $error("result word changed while stalled");

	// with the output register empty nothing can back up to the input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_DATA || status == ST_DONE || status == ST_OVER ||
			status == ST_TRUNC || status == ST_EXTRA))
		else $error("status code out of range");

	a_status_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_DATA |-> out_byte == '0)
		else $error("status word carries nonzero byte");

endmodule

bind netpbm_pixel_depth_reducer_core npdr_checker u_npdr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (pix_in.ready),
	.out_valid (pix_out.valid),
	.out_ready (pix_out.ready),
	.out_byte  (pix_out.out_byte),
	.status    (pix_out.status)
);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for netpbm_pixel_depth_reducer_core: a directed table, then random
// frames under random sender gaps and receiver stalls, each result checked against a predictor.
// Depends on npdr_pkg, npdr_if and the core.
module tb_top;
	import npdr_pkg::*;

	localparam int LIMIT = 300000;
	localparam int RANDOM_WORDS = 500;

	typedef struct packed {
		logic [SAMPLE_W-1:0] out_byte;
		status_t             status;
	} result_t;

	typedef enum logic {ROW_WORD, ROW_REG} row_kind_e;
	typedef enum logic [1:0] {CHK_PRED, CHK_NONE, CHK_WORD} row_chk_e;

	typedef struct packed {
		row_kind_e           kind;
		logic [CFG_IDX_W-1:0] index;
		logic [CFG_DATA_W-1:0] value;
		logic                eod;
		row_chk_e            chk;
		logic [SAMPLE_W-1:0] exp_byte;
		status_t             exp_status;
	} dir_row_t;

	localparam int DIR_N = 42;
	localparam dir_row_t DIR_TAB [DIR_N] = '{
		// reset defaults: 1x1 frame, bilevel, max 255
		'{ROW_WORD, REG_MODE,   13'h0A5, 1'b1, CHK_WORD, 8'h00, ST_TRUNC},
		'{ROW_WORD, REG_MODE,   13'd255, 1'b0, CHK_WORD, 8'h7F, ST_DATA},
		'{ROW_WORD, REG_MODE,   13'd0,   1'b1, CHK_WORD, 8'h00, ST_DONE},
		'{ROW_WORD, REG_MODE,   13'd0,   1'b0, CHK_WORD, 8'hFF, ST_DATA},
		'{ROW_WORD, REG_MODE,   13'd0,   1'b0, CHK_WORD, 8'h00, ST_EXTRA},
		'{ROW_WORD, REG_MODE,   13'd0,   1'b1, CHK_NONE, 8'h00, ST_DATA},
		'{ROW_REG,  REG_WIDTH,  13'd10,  1'b0, CHK_PRED, 8'h00, ST_DATA},
		'{ROW_REG,  REG_HEIGHT, 13'd2,   1'b0, CHK_PRED, 8'h00, ST_DATA},
		'{ROW_REG,  REG_MAXVAL, 13'd200, 1'b0, CHK_PRED, 8'h00, ST_DATA},
		// threshold sits at 100 for max 200
		'{ROW_WORD, REG_MODE,   13'd100, 1'b0, CHK_PRED, 8'h00, ST_DATA},
		'{ROW_WORD, REG_MODE,   13'd101, 1'b0, CHK_PRED, 8'h00, ST_DATA},
		'{ROW_WORD, REG_MODE,   13'd201, 1'b0, CHK_WORD, 8'h00, ST_OVER},
		'{ROW_WORD, REG_MODE,   13'd0,   1'b1, CHK_NONE, 8'h00, ST_DATA},
		'{ROW_REG,  REG_MODE,   13'd1,   1'b0, CHK_PRED, 8'h00, ST_DATA},
		'{ROW_REG,  REG_WIDTH,  13'd0,   1'b0, CHK_PRED, 8'h00, ST_DATA},
		'{ROW_REG,  REG_HEIGHT, 13'd0,   1'b0, CHK_PRED, 8'h00, ST_DATA},
		'{ROW_REG,  REG_MAXVAL, 13'd255, 1'b0, CHK_PRED, 8'h00, ST_DATA},
		'{ROW_WORD, REG_MODE,   13'd255, 1'b0, CHK_NONE, 8'h00, ST_DATA},
		'{ROW_WORD, REG_MODE,   13'd255, 1'b0, CHK_NONE, 8'h00, ST_DATA},
		'{ROW_WORD, REG_MODE,   13'd255, 1'b0, CHK_WORD, 8'hFF, ST_DATA},
		'{ROW_WORD, REG_MODE,   13'd0,   1'b1, CHK_WORD, 8'h00, ST_DONE},
		// partial triple at the end marker
		'{ROW_WORD, REG_MODE,   13'd7,   1'b0, CHK_NONE, 8'h00, ST_DATA},
		'{ROW_WORD, REG_MODE,   13'd0,   1'b1, CHK_WORD, 8'h00, ST_TRUNC},
		'{ROW_REG,  REG_MAXVAL, 13'd0,   1'b0, CHK_PRED, 8'h00, ST_DATA},
		'{ROW_WORD, REG_MODE,   13'd1,   1'b0, CHK_WORD, 8'h00, ST_OVER},
		'{ROW_WORD, REG_MODE,   13'd0,   1'b1, CHK_NONE, 8'h00, ST_DATA},
		'{ROW_REG,  REG_MODE,   13'd0,   1'b0, CHK_PRED, 8'h00, ST_DATA},
		'{ROW_WORD, REG_MODE,   13'd0,   1'b0, CHK_WORD, 8'hFF, ST_DATA},
		'{ROW_WORD, REG_MODE,   13'd0,   1'b1, CHK_WORD, 8'h00, ST_DONE},
		// width shrinks under a half-done row
		'{ROW_REG,  REG_WIDTH,  13'd4,   1'b0, CHK_PRED, 8'h00, ST_DATA},
		'{ROW_REG,  REG_HEIGHT, 13'd2,   1'b0, CHK_PRED, 8'h00, ST_DATA},
		'{ROW_REG,  REG_MAXVAL, 13'd255, 1'b0, CHK_PRED, 8'h00, ST_DATA},
		'{ROW_WORD, REG_MODE,   13'd200, 1'b0, CHK_PRED, 8'h00, ST_DATA},
		'{ROW_WORD, REG_MODE,   13'd10,  1'b0, CHK_PRED, 8'h00, ST_DATA},
		'{ROW_REG,  REG_WIDTH,  13'd2,   1'b0, CHK_PRED, 8'h00, ST_DATA},
		'{ROW_WORD, REG_MODE,   13'd0,   1'b0, CHK_PRED, 8'h00, ST_DATA},
		'{ROW_WORD, REG_MODE,   13'd0,   1'b1, CHK_PRED, 8'h00, ST_DATA},
		// oversized dimensions saturate
		'{ROW_REG,  REG_WIDTH,  13'd8191, 1'b0, CHK_PRED, 8'h00, ST_DATA},
		'{ROW_REG,  REG_HEIGHT, 13'd8191, 1'b0, CHK_PRED, 8'h00, ST_DATA},
		'{ROW_WORD, REG_MODE,   13'd0,   1'b0, CHK_PRED, 8'h00, ST_DATA},
		'{ROW_WORD, REG_MODE,   13'd255, 1'b0, CHK_PRED, 8'h00, ST_DATA},
		'{ROW_WORD, REG_MODE,   13'd0,   1'b1, CHK_WORD, 8'h00, ST_TRUNC}
	};

	logic clk;
	logic arst_n;

	npdr_in_if  pix_in();
	npdr_out_if pix_out();
	npdr_cfg_if cfg();

	netpbm_pixel_depth_reducer_core u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pix_in  (pix_in),
		.pix_out (pix_out),
		.cfg     (cfg)
	);

	// predictor copy of registers and frame state
	logic                  c_mode;
	logic [DIM_W-1:0]      c_width;
	logic [DIM_W-1:0]      c_height;
	logic [SAMPLE_W-1:0]   c_maxv;
	logic [11:0]           p_col;
	logic [11:0]           p_row;
	logic [7:0]            p_acc;
	logic [2:0]            p_pos;
	logic [1:0]            p_comp;
	logic [7:0]            p_red;
	logic [7:0]            p_green;
	bit                    p_err;
	bit                    p_done;

	result_t reduced_q[$];

	int cycle_cnt = 0;
	int fail_count = 0;
	int words_sent = 0;
	int words_checked = 0;
	int frames_sent = 0;
	int settings_used = 0;
	bit tx_steady = 1'b1;
	int tx_burst = 0;
	int rx_style = 0;
	int rx_left = 0;
	int rx_run = 0;
	logic rx_hold = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int eff_dim(input int v, input int lim);
		if (v == 0)
			return 1;
		if (v > lim)
			return lim;
		return v;
	endfunction

	function automatic void clear_frame();
		p_col = '0;
		p_row = '0;
		p_acc = '0;
		p_pos = '0;
		p_comp = COMP_RED;
		p_red = '0;
		p_green = '0;
		p_err = 1'b0;
		p_done = 1'b0;
	endfunction

	function automatic void step_position();
		if (int'(p_col) + 1 >= eff_dim(int'(c_width), DEF_MAX_WIDTH)) begin
			p_col = '0;
			if (int'(p_row) + 1 >= eff_dim(int'(c_height), DEF_MAX_HEIGHT)) begin
				p_row = '0;
				p_done = 1'b1;
			end else begin
				p_row = p_row + 12'd1;
			end
		end else begin
			p_col = p_col + 12'd1;
		end
	endfunction

	// returns 1 when the word yields a result, which is left in r
	function automatic bit reduce_word(input logic [7:0] s, input logic eod, output result_t r);
		int npos;
		int grey;
		bit row_end;
		bit ok;
		bit hit;
		logic [7:0] w;
		r = '0;
		if (eod) begin
			ok = p_done && (c_mode == MODE_BILEVEL || p_comp == COMP_RED);
			hit = !p_err;
			r.status = ok ? ST_DONE : ST_TRUNC;
			clear_frame();
			return hit;
		end
		if (p_err)
			return 1'b0;
		if (p_done) begin
			p_err = 1'b1;
			r.status = ST_EXTRA;
			return 1'b1;
		end
		if (s > c_maxv) begin
			p_err = 1'b1;
			r.status = ST_OVER;
			return 1'b1;
		end
		if (c_mode == MODE_BILEVEL) begin
			row_end = int'(p_col) + 1 >= eff_dim(int'(c_width), DEF_MAX_WIDTH);
			// dark samples set the bit
			if (!(int'(s) > (int'(c_maxv) + 1) / 2))
				p_acc[7 - p_pos] = 1'b1;
			npos = int'(p_pos) + 1;
			step_position();
			if (npos == 8 || row_end) begin
				w = p_acc;
				if (npos < 8)
					w = w | (8'hFF >> npos);
				p_acc = '0;
				p_pos = '0;
				r.out_byte = w;
				r.status = ST_DATA;
				return 1'b1;
			end
			p_pos = 3'(npos);
			return 1'b0;
		end
		if (p_comp == COMP_RED) begin
			p_red = s;
			p_comp = COMP_GREEN;
			return 1'b0;
		end
		if (p_comp == COMP_GREEN) begin
			p_green = s;
			p_comp = COMP_BLUE;
			return 1'b0;
		end
		grey = (299 * int'(p_red) + 587 * int'(p_green) + 114 * int'(s)) / 1000;
		p_comp = COMP_RED;
		step_position();
		r.out_byte = 8'(grey);
		r.status = ST_DATA;
		return 1'b1;
	endfunction

	function automatic logic [7:0] legal_sample();
		int t;
		if ($urandom_range(0, 3) == 0) begin
			// land on either side of the threshold
			t = (int'(c_maxv) + 1) / 2 + int'($urandom_range(0, 1));
			return (t > int'(c_maxv)) ? c_maxv : 8'(t);
		end
		return 8'($urandom_range(0, int'(c_maxv)));
	endfunction

	// stop feeding until every expected word is out, then let the pipe settle
	task automatic drain();
		@(negedge clk);
		pix_in.valid <= 1'b0;
		while (reduced_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		do @(posedge clk); while (!cfg.ready);
		case (idx)
			REG_MODE:   c_mode = val[0];
			REG_WIDTH:  c_width = val;
			REG_HEIGHT: c_height = val;
			default:    c_maxv = val[7:0];
		endcase
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic send_word(input logic [7:0] s, input logic eod, input row_chk_e chk,
			input result_t typed);
		result_t r;
		bit hit;
		if (!tx_steady && tx_burst == 0) begin
			@(negedge clk);
			pix_in.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			tx_burst = $urandom_range(1, 24);
		end
		if (tx_burst > 0)
			tx_burst--;
		@(negedge clk);
		pix_in.valid <= 1'b1;
		pix_in.sample <= s;
		pix_in.end_of_data <= eod;
		do @(posedge clk); while (!pix_in.ready);
		// words swallowed while an error is latched do not count
		if (!p_err || eod)
			words_sent++;
		hit = reduce_word(s, eod, r);
		case (chk)
			CHK_PRED: if (hit) reduced_q.push_back(r);
			CHK_WORD: reduced_q.push_back(typed);
			default: ;
		endcase
	endtask

	task automatic run_frame();
		int kind;
		int n;
		int stop_at;
		kind = $urandom_range(0, 19);
		n = 0;
		stop_at = (kind == 14 || kind == 15) ? $urandom_range(0, 47) : 48;
		while (!p_done && n < stop_at) begin
			if (kind == 19 && n == 2) begin
				drain();
				write_reg(($urandom_range(0, 1) == 0) ? REG_WIDTH : REG_HEIGHT,
					13'($urandom_range(1, 6)));
			end
			if (c_maxv != 8'hFF && $urandom_range(0, 49) == 0) begin
				send_word(8'($urandom_range(int'(c_maxv) + 1, 255)), 1'b0, CHK_PRED, '0);
				break;
			end
			if (kind == 18)
				send_word(8'($urandom), $urandom_range(0, 7) == 0, CHK_PRED, '0);
			else
				send_word(legal_sample(), 1'b0, CHK_PRED, '0);
			n++;
		end
		if (kind == 16 || kind == 17)
			repeat ($urandom_range(1, 3)) send_word(8'($urandom), 1'b0, CHK_PRED, '0);
		send_word(8'($urandom), 1'b1, CHK_PRED, '0);
		frames_sent++;
	endtask

	// receiver stall patterns, each picked at random and switched at random
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_style = $urandom_range(0, 3);
			rx_left = $urandom_range(20, 200);
		end
		rx_left--;
		case (rx_style)
			0: pix_out.ready <= 1'b1;
			1: pix_out.ready <= 1'($urandom_range(0, 1));
			2: pix_out.ready <= ($urandom_range(0, 3) == 0);
			default: begin
				if (rx_run == 0) begin
					rx_hold = !rx_hold;
					rx_run = $urandom_range(1, 12);
				end
				rx_run--;
				pix_out.ready <= rx_hold;
			end
		endcase
	end

	always @(posedge clk) begin : check_words
		result_t want;
		if (arst_n && pix_out.valid && pix_out.ready) begin
			if (reduced_q.size() == 0) begin
				$error("unexpected word: out_byte %0h status %0d", pix_out.out_byte,
					pix_out.status);
				fail_count++;
			end else begin
				want = reduced_q.pop_front();
				words_checked++;
				if (pix_out.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, pix_out.status);
					fail_count++;
				end
				if (pix_out.out_byte !== want.out_byte) begin
					$error("out_byte: expected %0h, got %0h", want.out_byte,
						pix_out.out_byte);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		int rand_start;
		arst_n = 1'b0;
		pix_in.valid = 1'b0;
		pix_in.sample = '0;
		pix_in.end_of_data = 1'b0;
		pix_out.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = REG_MODE;
		cfg.data = '0;
		c_mode = MODE_BILEVEL;
		c_width = 13'd1;
		c_height = 13'd1;
		c_maxv = 8'd255;
		clear_frame();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < DIR_N; i++) begin
			if (DIR_TAB[i].kind == ROW_REG) begin
				drain();
				write_reg(DIR_TAB[i].index, DIR_TAB[i].value);
			end else begin
				send_word(DIR_TAB[i].value[7:0], DIR_TAB[i].eod, DIR_TAB[i].chk,
					'{out_byte: DIR_TAB[i].exp_byte, status: DIR_TAB[i].exp_status});
			end
		end

		rand_start = words_sent;
		while (words_sent - rand_start < RANDOM_WORDS) begin
			drain();
			write_reg(REG_MODE, 13'($urandom_range(0, 1)));
			case ($urandom_range(0, 15))
				0: write_reg(REG_WIDTH, 13'd0);
				1: write_reg(REG_WIDTH, 13'd4096);
				2: write_reg(REG_WIDTH, 13'd8191);
				3: write_reg(REG_WIDTH, 13'($urandom_range(1, 8191)));
				default: write_reg(REG_WIDTH, 13'($urandom_range(1, 12)));
			endcase
			case ($urandom_range(0, 15))
				0: write_reg(REG_HEIGHT, 13'd0);
				1: write_reg(REG_HEIGHT, 13'd8191);
				2: write_reg(REG_HEIGHT, 13'd4096);
				default: write_reg(REG_HEIGHT, 13'($urandom_range(1, 4)));
			endcase
			case ($urandom_range(0, 7))
				0: write_reg(REG_MAXVAL, 13'd0);
				1: write_reg(REG_MAXVAL, 13'd1);
				2: write_reg(REG_MAXVAL, 13'($urandom_range(0, 255)));
				default: write_reg(REG_MAXVAL, 13'd255);
			endcase
			settings_used++;
			tx_steady = ($urandom_range(0, 3) == 0);
			tx_burst = 0;
			repeat ($urandom_range(1, 3)) run_frame();
		end

		drain();
		$display("%0d sample words over %0d random register settings and %0d frames",
			words_sent, settings_used, frames_sent);
		$display("%0d result words compared, %0d mismatches", words_checked, fail_count);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
